[hw/rtl/fractal_value_noise_pixel_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fractal value noise pixel core
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_PIXEL_CORE_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_PIXEL_CORE_DEFINES_SVH

// Generic clocked assertion with a synchronous reset disable.
`define FVN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the module's clock and reset.
`define FVN_ASSERT_CLK(lbl, prop, msg) \
   `FVN_ASSERT(lbl, clock, reset, prop, msg)

`endif

[hw/rtl/fvn_pkg.sv]
// ----------------------------------------------------------------------------
// fvn_pkg
// Types, constants and constant tables for the fractal value noise core.
// ----------------------------------------------------------------------------
`default_nettype none

package fvn_pkg;

   localparam int MAX_OCTAVES = 8;
   localparam int COORD_BITS  = 12;

   localparam int OIDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int CNT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int SAMP_W = 24;
   localparam int ACC_W  = SAMP_W + MAX_OCTAVES;
   localparam int NUM_W  = ACC_W + 8;
   localparam int DEN_W  = SAMP_W + MAX_OCTAVES;
   localparam int RCP_W  = NUM_W - 23;

   localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
   localparam logic [31:0] KEY_MUL_X  = 32'h1f123bb5;
   localparam logic [31:0] KEY_MUL_Y  = 32'h5f356495;
   localparam logic [31:0] SEED_STEP  = 32'd1013;
   localparam logic [SAMP_W-1:0] SAMPLE_MAX = 24'hffffff;

   localparam int CSR_IDX_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OCTAVE_COUNT = 4'd0,
      CSR_BASE_SEED    = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [ACC_W-1:0]      acc;
   } beat_type;

   typedef logic [DEN_W-1:0] den_tbl_type [MAX_OCTAVES];
   typedef logic [RCP_W-1:0] rcp_tbl_type [MAX_OCTAVES];

   // total octave weight times full-scale sample, for n octaves
   function automatic logic [63:0] den_value(int n);
      logic [63:0] w;
      w = (64'd1 << MAX_OCTAVES) - (64'd1 << (MAX_OCTAVES - n));
      return w * 64'(SAMPLE_MAX);
   endfunction

   // floor(2^NUM_W / d), restoring long division at elaboration
   function automatic logic [63:0] recip_value(logic [63:0] d);
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] q;
      num = 64'd1 << NUM_W;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= d) begin
            rem  = rem - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic den_tbl_type make_den_tbl();
      den_tbl_type t;
      for (int n = 1; n <= MAX_OCTAVES; n++) begin
         t[n-1] = DEN_W'(den_value(n));
      end
      return t;
   endfunction

   function automatic rcp_tbl_type make_rcp_tbl();
      rcp_tbl_type t;
      for (int n = 1; n <= MAX_OCTAVES; n++) begin
         t[n-1] = RCP_W'(recip_value(den_value(n)));
      end
      return t;
   endfunction

   localparam den_tbl_type DEN_TBL = make_den_tbl();
   localparam rcp_tbl_type RCP_TBL = make_rcp_tbl();

endpackage

`default_nettype wire

[hw/rtl/fvn_cell.sv]
// ----------------------------------------------------------------------------
// fvn_cell
// One octave of the noise sum: hashes four lattice corners, blends them and
// adds the weighted sample to the running accumulator. Six stages deep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fractal_value_noise_pixel_core_defines.svh"

module fvn_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic [fvn_pkg::OIDX_W-1:0] oct_idx,
   input  wire logic [fvn_pkg::CNT_W-1:0]  oct_count,
   input  wire logic [31:0]                base_seed,
   input  wire fvn_pkg::beat_type          in_beat,
   output fvn_pkg::beat_type               out_beat
);

   localparam int LINE = 5;

   function automatic logic [23:0] blend24(logic [23:0] a, logic [23:0] b, logic [15:0] s);
      logic [41:0] sum;
      sum = 42'(a) * 42'(17'd65536 - 17'(s)) + 42'(b) * 42'(s);
      return 24'(sum >> 16);
   endfunction

   logic en;

   // delay line for the beat while the octave is computed
   logic                          vld_ff [LINE];
   logic [fvn_pkg::COORD_BITS-1:0] x_ff  [LINE];
   logic [fvn_pkg::COORD_BITS-1:0] y_ff  [LINE];
   logic [fvn_pkg::ACC_W-1:0]      acc_ff[LINE];

   // stage 1
   logic [31:0] sx_w, sy_w, x0, y0;
   logic [15:0] tx_in, ty_in;
   logic [31:0] px0_in, py0_in, tx2_in, ty2_in, seed_in;
   logic [31:0] px0_ff, py0_ff, tx2_ff, ty2_ff, seed_ff;
   logic [15:0] tx_ff, ty_ff;

   // stage 2
   logic [31:0] px1, py1;
   logic [31:0] key  [4];
   logic [31:0] m1_in[4];
   logic [31:0] m1_ff[4];
   logic [15:0] sx_in, sy_in, sx_ff, sy_ff;

   // stage 3
   logic [31:0] m2_in[4];
   logic [31:0] m2_ff[4];
   logic [15:0] sx3_ff, sy3_ff;

   // stage 4
   logic [31:0] hm  [4];
   logic [23:0] top_in, bot_in, top_ff, bot_ff;
   logic [15:0] sy4_ff;

   // stage 5
   logic [23:0] val_in, val_ff;

   // stage 6
   logic [fvn_pkg::ACC_W-1:0] add_in;
   logic [fvn_pkg::ACC_W-1:0] out_acc_ff;
   logic [fvn_pkg::COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic out_vld_ff;

   assign en = fvn_pkg::CNT_W'(oct_idx) < oct_count;

   always_comb begin
      sx_w    = 32'(in_beat.x) << oct_idx;
      sy_w    = 32'(in_beat.y) << oct_idx;
      x0      = sx_w >> 6;
      y0      = sy_w >> 6;
      tx_in   = {sx_w[5:0], 10'b0};
      ty_in   = {sy_w[5:0], 10'b0};
      px0_in  = x0 * fvn_pkg::KEY_MUL_X;
      py0_in  = y0 * fvn_pkg::KEY_MUL_Y;
      tx2_in  = 32'(tx_in) * 32'(tx_in);
      ty2_in  = 32'(ty_in) * 32'(ty_in);
      seed_in = base_seed + 32'(oct_idx) * fvn_pkg::SEED_STEP;
   end

   always_comb begin
      px1    = px0_ff + fvn_pkg::KEY_MUL_X;
      py1    = py0_ff + fvn_pkg::KEY_MUL_Y;
      key[0] = px0_ff ^ py0_ff ^ seed_ff;
      key[1] = px1    ^ py0_ff ^ seed_ff;
      key[2] = px0_ff ^ py1    ^ seed_ff;
      key[3] = px1    ^ py1    ^ seed_ff;
      for (int i = 0; i < 4; i++) begin
         m1_in[i] = (key[i] ^ (key[i] >> 16)) * fvn_pkg::HASH_MUL_A;
         m2_in[i] = (m1_ff[i] ^ (m1_ff[i] >> 15)) * fvn_pkg::HASH_MUL_B;
         hm[i]    = m2_ff[i] ^ (m2_ff[i] >> 16);
      end
      sx_in = 16'((50'(tx2_ff) * 50'(18'd196608 - 18'({tx_ff, 1'b0}))) >> 32);
      sy_in = 16'((50'(ty2_ff) * 50'(18'd196608 - 18'({ty_ff, 1'b0}))) >> 32);
      top_in = blend24(hm[0][23:0], hm[1][23:0], sx3_ff);
      bot_in = blend24(hm[2][23:0], hm[3][23:0], sx3_ff);
      val_in = blend24(top_ff, bot_ff, sy4_ff);
      add_in = en ? (fvn_pkg::ACC_W'(val_ff)
                     << (fvn_pkg::OIDX_W'(fvn_pkg::MAX_OCTAVES - 1) - oct_idx))
                  : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px0_ff  <= px0_in;
         py0_ff  <= py0_in;
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
         tx2_ff  <= tx2_in;
         ty2_ff  <= ty2_in;
         seed_ff <= seed_in;
         m1_ff   <= m1_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         m2_ff   <= m2_in;
         sx3_ff  <= sx_ff;
         sy3_ff  <= sy_ff;
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         sy4_ff  <= sy3_ff;
         val_ff  <= val_in;
         x_ff[0]   <= in_beat.x;
         y_ff[0]   <= in_beat.y;
         acc_ff[0] <= in_beat.acc;
         for (int i = 1; i < LINE; i++) begin
            x_ff[i]   <= x_ff[i-1];
            y_ff[i]   <= y_ff[i-1];
            acc_ff[i] <= acc_ff[i-1];
         end
         out_x_ff   <= x_ff[LINE-1];
         out_y_ff   <= y_ff[LINE-1];
         out_acc_ff <= acc_ff[LINE-1] + add_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE; i++) begin
            vld_ff[i] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_beat.valid;
         for (int i = 1; i < LINE; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         out_vld_ff <= vld_ff[LINE-1];
      end
   end

   assign out_beat.valid = out_vld_ff;
   assign out_beat.x     = out_x_ff;
   assign out_beat.y     = out_y_ff;
   assign out_beat.acc   = out_acc_ff;

   `FVN_ASSERT_CLK(a_acc_grows, (vld_ff[LINE-1] && adv) |=> (out_acc_ff >= $past(acc_ff[LINE-1])), "accumulator decreased in octave cell")
   `FVN_ASSERT_CLK(a_idle_octave_pass, (vld_ff[LINE-1] && adv && !en) |=> (out_acc_ff == $past(acc_ff[LINE-1])), "unused octave changed the accumulator")
   `FVN_ASSERT_CLK(a_hold_on_stall, !adv |=> $stable(out_acc_ff) && $stable(out_vld_ff), "octave cell output moved while stalled")

endmodule

`default_nettype wire

[hw/rtl/fvn_norm.sv]
// ----------------------------------------------------------------------------
// fvn_norm
// Divides the accumulated sum by the total weight through a per-count
// reciprocal with one correction step, and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fractal_value_noise_pixel_core_defines.svh"

module fvn_norm (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic [fvn_pkg::CNT_W-1:0] oct_count,
   input  wire fvn_pkg::beat_type         in_beat,
   output logic                           out_valid,
   output logic [7:0]                     out_value
);

   localparam int PROD_W = fvn_pkg::NUM_W + fvn_pkg::RCP_W;
   localparam int QD_W   = 9 + fvn_pkg::DEN_W;

   logic [fvn_pkg::OIDX_W-1:0] idx;

   logic [fvn_pkg::NUM_W-1:0] num_in, num1_ff, num2_ff, num3_ff;
   logic [fvn_pkg::RCP_W-1:0] rcp1_ff;
   logic [fvn_pkg::DEN_W-1:0] den1_ff, den2_ff, den3_ff;
   logic [PROD_W-1:0]         prod_in, prod_ff;
   logic [8:0]                qe_in, qe_ff;
   logic [QD_W-1:0]           qd_in, qd_ff;
   logic [fvn_pkg::NUM_W-1:0] rem;
   logic [fvn_pkg::DEN_W:0]   den_x2;
   logic [8:0]                q;
   logic [7:0]                value_in, value_ff;
   logic                      vld1_ff, vld2_ff, vld3_ff, out_vld_ff;

   always_comb begin
      idx      = fvn_pkg::OIDX_W'(oct_count - fvn_pkg::CNT_W'(1));
      num_in   = (fvn_pkg::NUM_W'(in_beat.acc) << 8) - fvn_pkg::NUM_W'(in_beat.acc);
      prod_in  = PROD_W'(num1_ff) * PROD_W'(rcp1_ff);
      qe_in    = prod_ff[fvn_pkg::NUM_W +: 9];
      qd_in    = QD_W'(qe_in) * QD_W'(den2_ff);
      rem      = num3_ff - fvn_pkg::NUM_W'(qd_ff);
      den_x2   = {den3_ff, 1'b0};
      // estimate is low by at most one
      q        = qe_ff + ((rem >= fvn_pkg::NUM_W'(den3_ff)) ? 9'd1 : 9'd0);
      value_in = q[8] ? 8'hff : q[7:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff  <= num_in;
         rcp1_ff  <= fvn_pkg::RCP_TBL[idx];
         den1_ff  <= fvn_pkg::DEN_TBL[idx];
         prod_ff  <= prod_in;
         num2_ff  <= num1_ff;
         den2_ff  <= den1_ff;
         qe_ff    <= qe_in;
         qd_ff    <= qd_in;
         num3_ff  <= num2_ff;
         den3_ff  <= den2_ff;
         value_ff <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff    <= in_beat.valid;
         vld2_ff    <= vld1_ff;
         vld3_ff    <= vld2_ff;
         out_vld_ff <= vld3_ff;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_value = value_ff;

   `FVN_ASSERT_CLK(a_one_step_fix, vld3_ff |-> ((fvn_pkg::DEN_W + 1)'(rem) < den_x2), "reciprocal estimate off by more than one")
   `FVN_ASSERT_CLK(a_no_overflow, vld3_ff |-> !q[8], "normalized value above full scale")

endmodule

`default_nettype wire

[hw/rtl/fractal_value_noise_pixel_core.sv]
// ----------------------------------------------------------------------------
// fractal_value_noise_pixel_core
// Fractal value noise: one pixel coordinate in, one 8-bit density out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (req_pixel_x, req_pixel_y) are taken when req_valid is high
//   and req_stall is low; one rsp_pixel_value beat comes out per input beat,
//   in order. Throughput is one pixel per clock unless rsp_stall holds a result.
//   The pipeline is a row of octave cells, six stages each, followed by a
//   four-stage normalizer whose last stage is the output register. Every
//   cell runs for every pixel; cells past the programmed octave count pass
//   the accumulator unchanged.
//   Configuration is written through csr_write_en / csr_index /
//   csr_write_data while no pixel is in flight; index 0 is the octave count,
//   index 1 the base seed, other indexes are dropped.
//   Reset (synchronous) empties the pipeline and loads octave count 4 and
//   seed 0. While a result waits under rsp_stall the whole pipeline holds and
//   req_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module fractal_value_noise_pixel_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [fvn_pkg::COORD_BITS-1:0] req_pixel_x,
   input  wire logic [fvn_pkg::COORD_BITS-1:0] req_pixel_y,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_pixel_value,
   input  wire logic                           csr_write_en,
   input  wire logic [fvn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_write_data
);

   logic [3:0]                octave_count_ff;
   logic [31:0]               base_seed_ff;
   logic [fvn_pkg::CNT_W-1:0] oct_eff;
   logic                      adv;

   fvn_pkg::beat_type chain [fvn_pkg::MAX_OCTAVES + 1];

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= 4'd4;
         base_seed_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            fvn_pkg::CSR_OCTAVE_COUNT: octave_count_ff <= csr_write_data[3:0];
            fvn_pkg::CSR_BASE_SEED:    base_seed_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // saturate the octave count into 1..MAX_OCTAVES
   always_comb begin
      priority if (octave_count_ff == 4'd0) begin
         oct_eff = fvn_pkg::CNT_W'(1);
      end else if (32'(octave_count_ff) > 32'(fvn_pkg::MAX_OCTAVES)) begin
         oct_eff = fvn_pkg::CNT_W'(fvn_pkg::MAX_OCTAVES);
      end else begin
         oct_eff = fvn_pkg::CNT_W'(octave_count_ff);
      end
   end

   // advance unless a finished beat is held by the receiver
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   assign chain[0].valid = req_valid;
   assign chain[0].x     = req_pixel_x;
   assign chain[0].y     = req_pixel_y;
   assign chain[0].acc   = '0;

   for (genvar g = 0; g < fvn_pkg::MAX_OCTAVES; g++) begin : g_cell
      fvn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .oct_idx   (fvn_pkg::OIDX_W'(g)),
         .oct_count (oct_eff),
         .base_seed (base_seed_ff),
         .in_beat   (chain[g]),
         .out_beat  (chain[g+1])
      );
   end

   fvn_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .oct_count (oct_eff),
      .in_beat   (chain[fvn_pkg::MAX_OCTAVES]),
      .out_valid (rsp_valid),
      .out_value (rsp_pixel_value)
   );

endmodule

`default_nettype wire

[tb/tb_fractal_value_noise_pixel_core.sv]
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_pixel_core
// Drives pixel coordinates into the noise core under random valid and stall
// gaps, predicts each density in the bench and compares it beat for beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fractal_value_noise_pixel_core;

   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int DRAIN_CYCLES    = 6 * fvn_pkg::MAX_OCTAVES + 20;
   localparam int HOLD_OFF_CYCLES = 150;

   typedef struct {
      logic [fvn_pkg::COORD_BITS-1:0] x;
      logic [fvn_pkg::COORD_BITS-1:0] y;
   } pixel_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [fvn_pkg::COORD_BITS-1:0] req_pixel_x = '0;
   logic [fvn_pkg::COORD_BITS-1:0] req_pixel_y = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [7:0]                     rsp_pixel_value;
   logic                           csr_write_en = 1'b0;
   logic [fvn_pkg::CSR_IDX_W-1:0]  csr_index = fvn_pkg::CSR_OCTAVE_COUNT;
   logic [31:0]                    csr_write_data = '0;

   fractal_value_noise_pixel_core dut (.*);

   always #2 clock = ~clock;

   // bench copy of the configuration
   logic [3:0]  octaves_cfg = 4'd4;
   logic [31:0] seed_cfg    = '0;

   pixel_type   pending_pixels[$];
   logic [7:0]  expected_density[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_off_go = 1'b0;
   bit          hold_off_done = 1'b0;
   int          hold_off_cnt = 0;
   bit          req_taken = 1'b0;
   bit          failed = 1'b0;
   int          quiet_cycles = 0;

   function automatic logic [31:0] mix32(logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * fvn_pkg::HASH_MUL_A;
      v = v ^ (v >> 15);
      v = v * fvn_pkg::HASH_MUL_B;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic logic [63:0] lattice_sample(logic [31:0] cx, logic [31:0] cy,
                                                  logic [31:0] seed);
      return 64'(mix32((cx * fvn_pkg::KEY_MUL_X) ^ (cy * fvn_pkg::KEY_MUL_Y) ^ seed)
                 & 32'h00ffffff);
   endfunction

   function automatic logic [63:0] smooth_weight(logic [63:0] t);
      return ((t * t) * (64'd196608 - 2 * t)) >> 32;
   endfunction

   function automatic logic [63:0] mix_lerp(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] s);
      return (a * (64'd65536 - s) + b * s) >> 16;
   endfunction

   function automatic logic [7:0] predict_density(pixel_type p);
      logic [63:0] sx, sy, tx, ty, top, bot, acc, wsum, w, v;
      logic [31:0] x0, y0, seed;
      int n;
      acc  = '0;
      wsum = '0;
      n = octaves_cfg;
      if (n < 1) n = 1;
      if (n > fvn_pkg::MAX_OCTAVES) n = fvn_pkg::MAX_OCTAVES;
      for (int o = 0; o < n; o++) begin
         seed = seed_cfg + 32'(o) * fvn_pkg::SEED_STEP;
         sx = 64'(p.x) << o;
         sy = 64'(p.y) << o;
         x0 = 32'(sx >> 6);
         y0 = 32'(sy >> 6);
         tx = smooth_weight((sx & 64'd63) << 10);
         ty = smooth_weight((sy & 64'd63) << 10);
         top = mix_lerp(lattice_sample(x0, y0, seed), lattice_sample(x0 + 1, y0, seed), tx);
         bot = mix_lerp(lattice_sample(x0, y0 + 1, seed),
                        lattice_sample(x0 + 1, y0 + 1, seed), tx);
         w = 64'd1 << (fvn_pkg::MAX_OCTAVES - 1 - o);
         acc  += mix_lerp(top, bot, ty) * w;
         wsum += w;
      end
      v = (64'd255 * acc) / (wsum * 64'd16777215);
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // driver: offer the next pixel at the falling edge, hold it until taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_pixel_x <= pending_pixels[0].x;
               req_pixel_y <= pending_pixels[0].y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: one long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_go && !hold_off_done) begin
            rsp_stall    <= 1'b1;
            hold_off_cnt <= hold_off_cnt + 1;
            if (hold_off_cnt >= HOLD_OFF_CYCLES - 1) hold_off_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // monitor: accepted input beats make predictions, output beats are checked
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            pixel_type p;
            p = pending_pixels.pop_front();
            expected_density.push_back(predict_density(p));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_density.size() == 0) begin
               $error("pixel_value: unexpected beat, actual %0d", rsp_pixel_value);
               failed = 1'b1;
            end else begin
               logic [7:0] exp_v;
               exp_v = expected_density.pop_front();
               if (rsp_pixel_value !== exp_v) begin
                  $error("pixel_value: expected %0d actual %0d", exp_v, rsp_pixel_value);
                  failed = 1'b1;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_fractal_value_noise_pixel_core: errors");
            $finish;
         end
      end
   end

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p.x = fvn_pkg::COORD_BITS'($urandom());
      p.y = fvn_pkg::COORD_BITS'($urandom());
      return p;
   endfunction

   task automatic queue_pixel(int x, int y);
      pixel_type p;
      p.x = fvn_pkg::COORD_BITS'(x);
      p.y = fvn_pkg::COORD_BITS'(y);
      pending_pixels.push_back(p);
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() > 0 || expected_density.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write at the falling edge, update the bench copy once the edge takes it
   task automatic write_reg(fvn_pkg::csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      if (idx == fvn_pkg::CSR_OCTAVE_COUNT) octaves_cfg = data[3:0];
      else if (idx == fvn_pkg::CSR_BASE_SEED) seed_cfg = data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_unused_index();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= fvn_pkg::CSR_IDX_W'(4'hf);
      csr_write_data <= $urandom();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_phase(int count, int sidle, int ridle);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < count; i++) pending_pixels.push_back(rand_pixel());
      wait_idle();
   endtask

   initial begin
      logic [3:0] oct_settings[6];
      logic [31:0] seed_settings[6];
      oct_settings  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6};
      seed_settings = '{32'd0, 32'hffffffff, 32'h12345678, 32'h80000000, 32'd1, 32'hdeadbeef};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: coordinate extremes and cell-edge fractions
      queue_pixel(0, 0);        queue_pixel(4095, 4095);  queue_pixel(4095, 0);
      queue_pixel(0, 4095);     queue_pixel(63, 64);      queue_pixel(64, 63);
      queue_pixel(2730, 1365);  queue_pixel(1365, 2730);  queue_pixel(32, 32);
      queue_pixel(4032, 31);
      wait_idle();

      // long receiver hold-off while the sender keeps offering
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_go = 1'b1;
      for (int i = 0; i < 100; i++) pending_pixels.push_back(rand_pixel());
      wait_idle();

      for (int k = 0; k < 6; k++) begin
         write_reg(fvn_pkg::CSR_OCTAVE_COUNT, {28'($urandom()), oct_settings[k]});
         write_reg(fvn_pkg::CSR_BASE_SEED, seed_settings[k]);
         if (k == 2) write_unused_index();
         queue_pixel(0, 0);
         queue_pixel(4095, 4095);
         case (k % 3)
            0: random_phase(180, 20, 78);
            1: random_phase(180, 78, 20);
            default: random_phase(180, 0, 0);
         endcase
      end

      if (!failed) begin
         $display("tb_fractal_value_noise_pixel_core: clean");
      end else begin
         $display("tb_fractal_value_noise_pixel_core: errors");
      end
      $finish;
   end

endmodule

[fractal_value_noise_pixel_core.f]
+incdir+hw/rtl
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_cell.sv
hw/rtl/fvn_norm.sv
hw/rtl/fractal_value_noise_pixel_core.sv
tb/tb_fractal_value_noise_pixel_core.sv
